// File: src/dltq_pkg.sv
`default_nettype none
package dltq_pkg;

    typedef enum logic [1:0] {
        KIND_REGISTER   = 2'd0,
        KIND_UPDATE     = 2'd1,
        KIND_UNREGISTER = 2'd2,
        KIND_TICK       = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_ACTIVE = 2'd2
    } resp_code_t;

    localparam logic [31:0] DELAY_MAX = 32'hFFFF_FFFF;
    localparam logic [9:0]  MS_TO_US  = 10'd1000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_REG_MUL,
        S_REG_SET,
        S_RM_WALK,
        S_RM_NEXT,
        S_INS_WALK,
        S_INS_DONE,
        S_RESP,
        S_OUT_WAIT,
        S_TK_WALK,
        S_TK_SCAN,
        S_TK_EMIT,
        S_TK_HANDLE,
        S_TK_FIX
    } state_t;

    // controller commands
    typedef struct packed {
        logic load_item;
        logic reg_alloc;
        logic reg_mul;
        logic reg_set;
        logic upd_set;
        logic unreg_free;
        logic rm_start;
        logic rm_step;
        logic rm_next;
        logic ins_start;
        logic ins_step;
        logic ins_finish;
        logic tk_start;
        logic tk_step;
        logic scan_start;
        logic scan_step;
        logic emit;
        logic hit_load;
        logic hit_adv;
        logic hit_free;
        logic hit_reload;
        logic resp_load;
        logic resp_fail;
    } dp_cmd_t;

    // datapath status
    typedef struct packed {
        kind_t kind;
        logic  free_empty;
        logic  slot_active;
        logic  rm_found;
        logic  rm_end;
        logic  ins_stop;
        logic  tk_stop;
        logic  scan_stop;
        logic  hits_zero;
        logic  emit_last;
        logic  hit_done;
        logic  hit_oneshot;
        logic  out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: src/dltq_datapath.sv
`default_nettype none
module dltq_datapath #(
    parameter int NUM_SLOTS = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire  [55:0]          s_tdata,
    input  dltq_pkg::dp_cmd_t    cmd,
    output dltq_pkg::dp_stat_t   stat,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import dltq_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    // item fields
    kind_t       kind_reg;
    logic [4:0]  sid_reg;
    logic [23:0] dval_reg;
    logic        os_reg;
    logic [23:0] el_reg;

    logic [31:0]   delta_mem [NUM_SLOTS];
    logic [31:0]   period_mem [NUM_SLOTS];
    logic          oneshot_mem [NUM_SLOTS];
    logic [SW-1:0] link_mem [NUM_SLOTS];
    logic [SW-1:0] fifo_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] fifo_init_reg;

    logic [SW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [CW-1:0] free_cnt_reg;

    // walk registers
    logic [SW-1:0] slot_reg;      // slot being removed or inserted
    logic [SW-1:0] cur_reg, prev_reg;
    logic          has_prev_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0]   d_reg;
    logic [41:0]   prod_reg;

    // hit list
    logic [SW-1:0] hits_mem [NUM_SLOTS];
    logic [CW-1:0] nhits_reg;
    logic [CW-1:0] hidx_reg;

    // result register
    logic          ovalid_reg;
    logic [1:0]    ost_reg;
    logic [4:0]    oslot_reg;
    logic          oexp_reg;
    logic          olast_reg;

    logic [SW-1:0] cur_link;
    logic [31:0]   cur_delta;
    logic          sid_ok;
    logic [SW-1:0] sid_idx;
    logic [SW-1:0] fifo_head;
    logic [32:0]   sum;
    logic [SW-1:0] hit_slot;

    assign cur_link  = link_mem[cur_reg];
    assign cur_delta = delta_mem[cur_reg];
    assign sid_ok    = 32'(sid_reg) < 32'(NUM_SLOTS);
    assign sid_idx   = SW'(sid_reg);
    assign fifo_head = fifo_init_reg[rd_ptr_reg] ? fifo_mem[rd_ptr_reg] : rd_ptr_reg;
    assign sum       = {1'b0, cur_delta} + {1'b0, delta_mem[slot_reg]};
    assign hit_slot  = hits_mem[SW'(hidx_reg)];

    always_comb begin
        stat.kind        = kind_reg;
        stat.free_empty  = free_cnt_reg == '0;
        stat.slot_active = sid_ok && active_reg[sid_idx];
        stat.rm_found    = cur_reg == slot_reg;
        stat.rm_end      = idx_reg >= count_reg;
        stat.ins_stop    = (idx_reg >= count_reg) || (d_reg < cur_delta);
        stat.tk_stop     = (idx_reg >= count_reg) || (32'(el_reg) < cur_delta);
        stat.scan_stop   = (idx_reg >= count_reg) || (cur_delta != '0);
        stat.hits_zero   = nhits_reg == '0;
        stat.emit_last   = hidx_reg + 1'b1 >= nhits_reg;
        stat.hit_done    = hidx_reg >= nhits_reg;
        stat.hit_oneshot = oneshot_mem[hit_slot];
        stat.out_busy    = ovalid_reg && !m_tready;
    end

    function automatic logic [SW-1:0] winc(input logic [SW-1:0] p);
        return (32'(p) + 1 >= NUM_SLOTS) ? '0 : p + 1'b1;
    endfunction

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= '0;
            fifo_init_reg <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            free_cnt_reg  <= CW'(NUM_SLOTS);
            ovalid_reg    <= 1'b0;
        end else begin
            if (ovalid_reg && m_tready) ovalid_reg <= 1'b0;
            if (cmd.resp_load || cmd.emit) ovalid_reg <= 1'b1;
            if (cmd.reg_alloc) begin
                rd_ptr_reg   <= winc(rd_ptr_reg);
                free_cnt_reg <= free_cnt_reg - 1'b1;
            end
            if (cmd.reg_set) active_reg[slot_reg] <= 1'b1;
            if (cmd.unreg_free || cmd.hit_free) begin
                active_reg[slot_reg] <= 1'b0;
                if (free_cnt_reg < CW'(NUM_SLOTS)) begin
                    fifo_init_reg[wr_ptr_reg] <= 1'b1;
                    wr_ptr_reg   <= winc(wr_ptr_reg);
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                end
            end
            if (cmd.rm_step && cur_reg == slot_reg) begin
                if (!has_prev_reg) head_reg <= cur_link;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.ins_finish) begin
                if (!has_prev_reg) head_reg <= slot_reg;
                if (count_reg < CW'(NUM_SLOTS)) count_reg <= count_reg + 1'b1;
            end
        end
    end

    // payload and memories
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= kind_t'(s_tdata[1:0]);
            sid_reg  <= s_tdata[6:2];
            dval_reg <= s_tdata[30:7];
            os_reg   <= s_tdata[31];
            el_reg   <= s_tdata[55:32];
        end
        if (cmd.reg_alloc) slot_reg <= fifo_head;
        if (cmd.reg_mul) prod_reg <= 42'(dval_reg) * 42'(MS_TO_US);
        if (cmd.reg_set) begin
            logic [31:0] d;
            d = (prod_reg > 42'(DELAY_MAX)) ? DELAY_MAX : prod_reg[31:0];
            if (d == '0) d = 32'd1;
            delta_mem[slot_reg]   <= d;
            period_mem[slot_reg]  <= d;
            oneshot_mem[slot_reg] <= os_reg;
        end
        if (cmd.upd_set) begin
            delta_mem[slot_reg]  <= (dval_reg == '0) ? 32'd1 : 32'(dval_reg);
            period_mem[slot_reg] <= (dval_reg == '0) ? 32'd1 : 32'(dval_reg);
        end
        if (cmd.rm_start) begin
            if (kind_reg != KIND_TICK) slot_reg <= sid_idx;
            cur_reg      <= head_reg;
            has_prev_reg <= 1'b0;
            idx_reg      <= '0;
        end
        if (cmd.rm_step) begin
            if (cur_reg == slot_reg) begin
                if (has_prev_reg) link_mem[prev_reg] <= cur_link;
                cur_reg <= cur_link;
            end else begin
                prev_reg     <= cur_reg;
                has_prev_reg <= 1'b1;
                cur_reg      <= cur_link;
                idx_reg      <= idx_reg + 1'b1;
            end
        end
        // add removed delta to successor
        if (cmd.rm_next)
            delta_mem[cur_reg] <= sum[32] ? DELAY_MAX : sum[31:0];
        if (cmd.ins_start) begin
            d_reg        <= delta_mem[slot_reg];
            cur_reg      <= head_reg;
            has_prev_reg <= 1'b0;
            idx_reg      <= '0;
        end
        if (cmd.ins_step) begin
            d_reg        <= d_reg - cur_delta;
            prev_reg     <= cur_reg;
            has_prev_reg <= 1'b1;
            cur_reg      <= cur_link;
            idx_reg      <= idx_reg + 1'b1;
        end
        if (cmd.ins_finish) begin
            if (idx_reg < count_reg) delta_mem[cur_reg] <= cur_delta - d_reg;
            delta_mem[slot_reg] <= d_reg;
            link_mem[slot_reg]  <= (idx_reg < count_reg) ? cur_reg : '0;
            if (has_prev_reg) link_mem[prev_reg] <= slot_reg;
        end
        if (cmd.tk_start || cmd.scan_start) begin
            cur_reg <= head_reg;
            idx_reg <= '0;
        end
        if (cmd.scan_start) nhits_reg <= '0;
        // entries past the tail are never touched
        if (cmd.tk_step) begin
            if (idx_reg < count_reg && 32'(el_reg) >= cur_delta) begin
                el_reg             <= el_reg - cur_delta[23:0];
                delta_mem[cur_reg] <= '0;
                cur_reg            <= cur_link;
                idx_reg            <= idx_reg + 1'b1;
            end else if (idx_reg < count_reg) begin
                delta_mem[cur_reg] <= cur_delta - 32'(el_reg);
            end
        end
        if (cmd.scan_step) begin
            hits_mem[SW'(nhits_reg)] <= cur_reg;
            nhits_reg <= nhits_reg + 1'b1;
            cur_reg   <= cur_link;
            idx_reg   <= idx_reg + 1'b1;
        end
        if (cmd.scan_start || cmd.emit && stat.emit_last) hidx_reg <= '0;
        else if (cmd.emit || cmd.hit_adv) hidx_reg <= hidx_reg + 1'b1;
        if (cmd.hit_load) slot_reg <= hit_slot;
        if (cmd.hit_reload) delta_mem[slot_reg] <= period_mem[slot_reg];
        if (cmd.unreg_free || cmd.hit_free)
            if (free_cnt_reg < CW'(NUM_SLOTS)) fifo_mem[wr_ptr_reg] <= slot_reg;
        if (cmd.resp_load) begin
            oexp_reg  <= 1'b0;
            olast_reg <= 1'b1;
            case (kind_reg)
                KIND_REGISTER: begin
                    ost_reg   <= cmd.resp_fail ? ST_NO_FREE : ST_OK;
                    oslot_reg <= cmd.resp_fail ? 5'd0 : 5'(slot_reg);
                end
                KIND_TICK: begin
                    ost_reg   <= ST_OK;
                    oslot_reg <= '0;
                end
                default: begin
                    ost_reg   <= cmd.resp_fail ? ST_NOT_ACTIVE : ST_OK;
                    oslot_reg <= sid_reg;
                end
            endcase
        end
        if (cmd.emit) begin
            ost_reg   <= ST_OK;
            oslot_reg <= 5'(hit_slot);
            oexp_reg  <= 1'b1;
            olast_reg <= stat.emit_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {oexp_reg, oslot_reg, ost_reg};
    assign m_tlast  = olast_reg;
endmodule
`default_nettype wire

// File: src/dltq_ctrl.sv
`default_nettype none
module dltq_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  dltq_pkg::dp_stat_t   stat,
    output dltq_pkg::dp_cmd_t    cmd
);
    import dltq_pkg::*;

    state_t state_reg, state_next;
    logic   fail_reg, fail_next;   // no free slot or slot not active
    logic   tick_reg, tick_next;   // removal and insertion belong to a tick

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fail_reg  <= 1'b0;
            tick_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fail_reg  <= fail_next;
            tick_reg  <= tick_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fail_next  = fail_reg;
        tick_next  = tick_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = !stat.out_busy;
                if (s_tvalid && !stat.out_busy) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                fail_next = 1'b0;
                tick_next = 1'b0;
                case (stat.kind)
                    KIND_REGISTER: begin
                        if (stat.free_empty) begin
                            fail_next  = 1'b1;
                            state_next = S_RESP;
                        end else begin
                            cmd.reg_alloc = 1'b1;
                            cmd.reg_mul   = 1'b1;
                            state_next    = S_REG_SET;
                        end
                    end
                    KIND_TICK: begin
                        tick_next    = 1'b1;
                        cmd.tk_start = 1'b1;
                        state_next   = S_TK_WALK;
                    end
                    default: begin
                        if (stat.slot_active) begin
                            cmd.rm_start = 1'b1;
                            state_next   = S_RM_WALK;
                        end else begin
                            fail_next  = 1'b1;
                            state_next = S_RESP;
                        end
                    end
                endcase
            end
            S_REG_MUL: state_next = S_REG_SET;
            S_REG_SET: begin
                cmd.reg_set = 1'b1;
                state_next  = S_INS_DONE;
            end
            S_RM_WALK: begin
                if (stat.rm_end) begin
                    state_next = S_RM_NEXT;
                end else begin
                    cmd.rm_step = 1'b1;
                    if (stat.rm_found) state_next = S_RM_NEXT;
                end
            end
            S_RM_NEXT: begin
                // successor exists when the walk did not end past the tail
                if (!stat.rm_end) cmd.rm_next = 1'b1;
                if (!tick_reg && stat.kind == KIND_UPDATE) begin
                    cmd.upd_set = 1'b1;
                    state_next  = S_INS_DONE;
                end else if (!tick_reg) begin
                    cmd.unreg_free = 1'b1;
                    state_next     = S_RESP;
                end else if (stat.hit_oneshot) begin
                    cmd.hit_free = 1'b1;
                    cmd.hit_adv  = 1'b1;
                    state_next   = S_TK_HANDLE;
                end else begin
                    cmd.hit_reload = 1'b1;
                    state_next     = S_INS_DONE;
                end
            end
            S_INS_DONE: begin
                cmd.ins_start = 1'b1;
                state_next    = S_INS_WALK;
            end
            S_INS_WALK: begin
                if (stat.ins_stop) begin
                    cmd.ins_finish = 1'b1;
                    if (tick_reg) begin
                        cmd.hit_adv = 1'b1;
                        state_next  = S_TK_HANDLE;
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    cmd.ins_step = 1'b1;
                end
            end
            S_RESP: begin
                if (!stat.out_busy) begin
                    cmd.resp_load = 1'b1;
                    cmd.resp_fail = fail_reg;
                    state_next    = S_IDLE;
                end
            end
            S_TK_WALK: begin
                cmd.tk_step = 1'b1;
                if (stat.tk_stop) state_next = S_TK_FIX;
            end
            S_TK_FIX: begin
                cmd.scan_start = 1'b1;
                state_next     = S_TK_SCAN;
            end
            S_TK_SCAN: begin
                if (stat.scan_stop) begin
                    state_next = stat.hits_zero ? S_RESP : S_TK_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_TK_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) state_next = S_TK_HANDLE;
                end
            end
            S_TK_HANDLE: begin
                if (stat.hit_done) begin
                    state_next = S_OUT_WAIT;
                end else begin
                    cmd.hit_load = 1'b1;
                    cmd.rm_start = 1'b1;
                    state_next   = S_RM_WALK;
                end
            end
            S_OUT_WAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: src/delta_list_timer_queue.sv
`default_nettype none
// delta-list timer queue: one transaction in, one or more result transactions out
// tick: consume elapsed time, scan expired entries, emit one result per expiry, then reinsert or free each
// throughput: one item at a time, set by the single list-walk port (one entry per cycle)
// reset: aresetn synchronous active low; list empty, all slots free in order 0 upward
module delta_list_timer_queue #(
    parameter int NUM_SLOTS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata: kind[1:0], slot_id[6:2], delay_value[30:7], one_shot[31], elapsed_us[55:32]
    input  wire  [55:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata: status[1:0], slot_out[6:2], expired[7]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    import dltq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: walks list insertion, removal and tick phases
    dltq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot tables, free fifo, list walker and result register
    dltq_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire
